@@ hdl/nuq_pkg.sv @@
// ============================================================================
// nuq_pkg - shared types and constants for the nearest upscale quantizer
// Geometry, field widths, register codes, the queue entry and the result
// side-band, plus the output-to-source coordinate map.
// ============================================================================
package nuq_pkg;

  // Image geometry (square source and destination)
  localparam int SRC_SIDE = 28;
  localparam int DST_SIDE = 32;

  // Source coordinate width and destination counter width (holds DST_SIDE)
  localparam int SRC_W   = $clog2(SRC_SIDE);
  localparam int CNT_W   = $clog2(DST_SIDE + 1);
  localparam int COORD_W = 5;

  // Field widths
  localparam int PIX_W   = 8;
  localparam int GAIN_W  = 24;
  localparam int ZERO_W  = 8;
  localparam int QUANT_W = 8;
  localparam int PROD_W  = PIX_W + GAIN_W;
  localparam int FRAC_W  = 16;
  localparam int SUM_W   = PROD_W - FRAC_W + 2;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = GAIN_W;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO = 1'd1;

  localparam logic [GAIN_W-1:0] GAIN_RST = 24'd65536;
  localparam logic [ZERO_W-1:0] ZERO_RST = 8'h80;

  // Front-to-back queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One classified source pixel
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             frame_start;
    logic [SRC_W-1:0] src_col;
    logic [SRC_W-1:0] src_row;
    logic             row_end;
    logic             frame_end;
  } item_t;

  // Side-band that travels with a result through the back pipeline
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               run_last;
    logic               frame_last;
  } meta_t;

  // Destination coordinate to source coordinate: floor(d*SRC/DST)
  function automatic logic [SRC_W-1:0] map_coord(input logic [CNT_W-1:0] d);
    int m;
    m = (int'(d) * SRC_SIDE) / DST_SIDE;
    return SRC_W'(m);
  endfunction

endpackage

@@ hdl/nuq_front.sv @@
// ============================================================================
// nuq_front - input side of the quantizer
// Accepts source pixels, tracks the source position, applies frame_start
// and tags each pixel with its coordinates and row/frame end flags.
// ============================================================================
module nuq_front import nuq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] in_pixel,
  input  logic             in_frame_start,
  input  logic             q_full,
  output logic             q_push,
  output item_t            q_item
);

  logic [SRC_W-1:0] src_col_r;
  logic [SRC_W-1:0] src_row_r;
  logic [SRC_W-1:0] col_eff;
  logic [SRC_W-1:0] row_eff;
  logic             row_end;
  logic             frame_end;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // frame_start clears the position before this pixel is placed
  assign col_eff   = in_frame_start ? '0 : src_col_r;
  assign row_eff   = in_frame_start ? '0 : src_row_r;
  assign row_end   = (col_eff == SRC_W'(SRC_SIDE - 1));
  assign frame_end = row_end && (row_eff == SRC_W'(SRC_SIDE - 1));

  always_comb begin
    q_item.pix         = in_pixel;
    q_item.frame_start = in_frame_start;
    q_item.src_col     = col_eff;
    q_item.src_row     = row_eff;
    q_item.row_end     = row_end;
    q_item.frame_end   = frame_end;
  end

  // Source position counters: the column wraps at a row end, the row at the end of a frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r <= '0;
      src_row_r <= '0;
    end else if (q_push) begin
      if (row_end) begin
        src_col_r <= '0;
        src_row_r <= frame_end ? '0 : row_eff + SRC_W'(1);
      end else begin
        src_col_r <= col_eff + SRC_W'(1);
        src_row_r <= row_eff;
      end
    end
  end

endmodule

@@ hdl/nuq_queue.sv @@
// ============================================================================
// nuq_queue - short FIFO between front and back
// Holds classified pixels so the input side keeps taking transactions while
// the back end replays a row or waits on the output.
// ============================================================================
module nuq_queue import nuq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head_item
);

  item_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = slot_r[rd_ptr_r];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + QCNT_W'(1);
      else if (!push && pop) count_r <= count_r - QCNT_W'(1);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

@@ hdl/nuq_back.sv @@
// ============================================================================
// nuq_back - output sequencer, line store and quantizer pipeline
// Walks the output columns of each source pixel, replays stored rows at a
// row end, and scales, rounds, offsets and clamps every result.
// ============================================================================
module nuq_back import nuq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // queue head
  input  logic                  q_valid,
  input  item_t                 q_item,
  output logic                  q_pop,
  // results
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [QUANT_W-1:0]    out_quant_value,
  output logic [COORD_W-1:0]    out_col,
  output logic [COORD_W-1:0]    out_row,
  output logic                  out_run_last,
  output logic                  out_frame_last
);

  typedef enum logic {ST_COLS, ST_REPLAY} state_t;

  // Sequencer state
  state_t           state_r, state_nxt;
  logic             first_r, first_nxt;
  logic [CNT_W-1:0] dc_r, dc_nxt;
  logic [CNT_W-1:0] dr_r, dr_nxt;
  logic [CNT_W-1:0] x_r, x_nxt;

  // Configuration
  logic [GAIN_W-1:0] gain_r;
  logic [ZERO_W-1:0] zero_r;

  // Line store
  logic [PIX_W-1:0] line_store [SRC_SIDE];
  logic [PIX_W-1:0] rdata_r;

  // Pipeline
  logic              adv;
  logic              s1_valid_r;
  logic              s1_store_r;
  logic [PIX_W-1:0]  s1_pix_r;
  meta_t             s1_meta_r;
  logic              s2_valid_r;
  logic [PROD_W-1:0] s2_prod_r;
  meta_t             s2_meta_r;
  logic              out_valid_r;
  logic [QUANT_W-1:0] quant_r;
  meta_t             out_meta_r;

  // Sequencer combinational terms
  logic [CNT_W-1:0] dc_e, dr_e, dc_inc, dr_a, dr_inc;
  logic             col_hit, col_more, row_hit, rep_any, rep_more, x_end;
  logic             iss_valid, iss_store, iss_last, pop_c, ls_we;
  logic [CNT_W-1:0] iss_col, iss_row;
  meta_t            iss_meta;

  // Quantizer terms
  logic [PIX_W-1:0]      mul_pix;
  logic [PROD_W-1:0]     rnd;
  logic signed [SUM_W-1:0] qsum;
  logic [QUANT_W-1:0]    qclamp;

  assign adv = !out_valid_r || out_ready;

  // ---- configuration registers -------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RST;
      zero_r <= ZERO_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GAIN: gain_r <= cfg_data[GAIN_W-1:0];
        CFG_ZERO: zero_r <= cfg_data[ZERO_W-1:0];
        default:  ;
      endcase
    end
  end

  // ---- mapping lookups ----------------------------------------------------
  assign dc_e     = (first_r && q_item.frame_start) ? '0 : dc_r;
  assign dr_e     = (first_r && q_item.frame_start) ? '0 : dr_r;
  assign dc_inc   = dc_e + CNT_W'(1);
  assign col_hit  = (dc_e < CNT_W'(DST_SIDE)) && (map_coord(dc_e) == q_item.src_col);
  assign col_more = (dc_inc < CNT_W'(DST_SIDE)) && (map_coord(dc_inc) == q_item.src_col);
  assign row_hit  = (dr_e < CNT_W'(DST_SIDE)) && (map_coord(dr_e) == q_item.src_row);
  assign dr_a     = dr_e + CNT_W'(row_hit);
  assign rep_any  = q_item.row_end && (dr_a < CNT_W'(DST_SIDE)) &&
                    (map_coord(dr_a) == q_item.src_row);
  assign dr_inc   = dr_r + CNT_W'(1);
  assign rep_more = (dr_inc < CNT_W'(DST_SIDE)) && (map_coord(dr_inc) == q_item.src_row);
  assign x_end    = (x_r == CNT_W'(DST_SIDE - 1));

  // ---- sequencer next state -----------------------------------------------
  always_comb begin
    state_nxt = state_r;
    first_nxt = first_r;
    dc_nxt    = dc_r;
    dr_nxt    = dr_r;
    x_nxt     = x_r;
    iss_valid = 1'b0;
    iss_store = 1'b0;
    iss_last  = 1'b0;
    iss_col   = dc_e;
    iss_row   = dr_e;
    pop_c     = 1'b0;
    ls_we     = 1'b0;
    if (q_valid) begin
      unique case (state_r)
        ST_COLS: begin
          ls_we     = 1'b1;
          first_nxt = 1'b0;
          dc_nxt    = dc_e;
          dr_nxt    = dr_e;
          if (col_hit) begin
            iss_valid = row_hit;
            iss_last  = !col_more && !rep_any;
            dc_nxt    = dc_inc;
            if (!col_more && !q_item.row_end) begin
              pop_c     = 1'b1;
              first_nxt = 1'b1;
            end
          end else if (q_item.row_end) begin
            dc_nxt = '0;
            if (rep_any) begin
              state_nxt = ST_REPLAY;
              x_nxt     = '0;
              dr_nxt    = dr_a;
            end else begin
              dr_nxt    = q_item.frame_end ? '0 : dr_a;
              pop_c     = 1'b1;
              first_nxt = 1'b1;
            end
          end else begin
            pop_c     = 1'b1;
            first_nxt = 1'b1;
          end
        end
        ST_REPLAY: begin
          iss_valid = 1'b1;
          iss_store = 1'b1;
          iss_col   = x_r;
          iss_row   = dr_r;
          iss_last  = x_end && !rep_more;
          x_nxt     = x_r + CNT_W'(1);
          if (x_end) begin
            x_nxt = '0;
            if (rep_more) begin
              dr_nxt = dr_inc;
            end else begin
              dr_nxt    = q_item.frame_end ? '0 : dr_inc;
              state_nxt = ST_COLS;
              pop_c     = 1'b1;
              first_nxt = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign q_pop = adv && pop_c;

  always_comb begin
    iss_meta.col        = iss_col[COORD_W-1:0];
    iss_meta.row        = iss_row[COORD_W-1:0];
    iss_meta.run_last   = iss_last;
    iss_meta.frame_last = (iss_col == CNT_W'(DST_SIDE - 1)) &&
                          (iss_row == CNT_W'(DST_SIDE - 1));
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLS;
      first_r <= 1'b1;
      dc_r    <= '0;
      dr_r    <= '0;
      x_r     <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      dc_r    <= dc_nxt;
      dr_r    <= dr_nxt;
      x_r     <= x_nxt;
    end
  end

  // ---- line store: write current pixel, registered replay read ------------
  always_ff @(posedge clk) begin
    if (adv && ls_we) line_store[q_item.src_col] <= q_item.pix;
    if (adv) rdata_r <= line_store[map_coord(x_r)];
  end

  // ---- pipeline valids ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= iss_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // Multiply stage input: live pixel or replayed pixel
  assign mul_pix = s1_store_r ? rdata_r : s1_pix_r;

  // Round half up, add zero point, clamp to int8
  always_comb begin
    rnd  = s2_prod_r + PROD_W'(32'd32768);
    qsum = $signed({2'b00, rnd[PROD_W-1:FRAC_W]}) +
           SUM_W'($signed(zero_r));
    if (qsum < -SUM_W'(128))      qclamp = 8'h80;
    else if (qsum > SUM_W'(127))  qclamp = 8'h7F;
    else                          qclamp = qsum[QUANT_W-1:0];
  end

  // ---- pipeline payload ----------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_store_r <= iss_store;
      s1_pix_r   <= q_item.pix;
      s1_meta_r  <= iss_meta;
      s2_prod_r  <= PROD_W'(mul_pix) * PROD_W'(gain_r);
      s2_meta_r  <= s1_meta_r;
      quant_r    <= qclamp;
      out_meta_r <= s2_meta_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_quant_value = quant_r;
  assign out_col         = out_meta_r.col;
  assign out_row         = out_meta_r.row;
  assign out_run_last    = out_meta_r.run_last;
  assign out_frame_last  = out_meta_r.frame_last;

endmodule

@@ hdl/nearest_upscale_int8_quantizer.sv @@
// ============================================================================
// nearest_upscale_int8_quantizer - nearest neighbor resize with int8 output
// Resizes a square grey image by nearest neighbor and quantizes every output
// pixel to int8 with a programmable Q16 gain and zero point.
// ============================================================================
//
//  Channel  Direction  Handshake            Payload
//  in_      input      in_valid/in_ready    in_pixel, in_frame_start
//  out_     output     out_valid/out_ready  out_quant_value, out_col, out_row,
//                                           out_run_last, out_frame_last
//  cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  The back end walks the output columns of each source pixel (at least
//  one), takes an extra step at each source row end, and replays every
//  further output row of that source row, one pixel per cycle unless the
//  output stalls; results pass the s1, s2 and output registers. The input
//  side buffers two transactions. Reset is synchronous and needs no
//  clearing pass. A stalled output freezes the whole back end; the input
//  keeps taking transactions until the queue fills. cfg_ready is always high.
//
module nearest_upscale_int8_quantizer import nuq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      in_pixel,
  input  logic                  in_frame_start,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [QUANT_W-1:0]    out_quant_value,
  output logic [COORD_W-1:0]    out_col,
  output logic [COORD_W-1:0]    out_row,
  output logic                  out_run_last,
  output logic                  out_frame_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic  q_push, q_full, q_pop, q_not_empty;
  item_t push_item, head_item;

  // Input classification
  nuq_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (push_item)
  );

  // Decoupling queue
  nuq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  // Sequencer, line store and quantizer
  nuq_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_valid         (q_not_empty),
    .q_item          (head_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_quant_value (out_quant_value),
    .out_col         (out_col),
    .out_row         (out_row),
    .out_run_last    (out_run_last),
    .out_frame_last  (out_frame_last)
  );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_top - testbench for nearest_upscale_int8_quantizer
// Feeds grey source pixels through the valid/ready input with random gaps,
// stalls the result side at random and checks every output pixel, field by
// field, against an in-bench resize and quantize predictor. Gain and zero
// point are reprogrammed between phases while the block is idle.
// ============================================================================
module tb_top import nuq_pkg::*; ();

  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE      = 16;

  // One source pixel waiting to be driven
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } src_pixel_t;

  // One expected output pixel
  typedef struct packed {
    logic [QUANT_W-1:0] quant;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               run_last;
    logic               frame_last;
  } out_pixel_t;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      in_pixel       = '0;
  logic                  in_frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [QUANT_W-1:0]    out_quant_value;
  logic [COORD_W-1:0]    out_col;
  logic [COORD_W-1:0]    out_row;
  logic                  out_run_last;
  logic                  out_frame_last;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  // Stimulus and expectation stores
  src_pixel_t pixel_q[$];
  out_pixel_t quant_q[$];

  // Predictor copy of the block's registers and state
  logic [GAIN_W-1:0]        gain_cfg = GAIN_RST;
  logic signed [ZERO_W-1:0] zero_cfg = ZERO_RST;
  logic [PIX_W-1:0]         row_buf [SRC_SIDE];
  int                       scol = 0;
  int                       srow = 0;
  int                       dcol = 0;
  int                       drow = 0;
  out_pixel_t               held;
  logic                     held_ok;

  // Handshake bookkeeping
  logic       in_fire      = 1'b0;
  int         in_gap       = 0;
  int         out_gap      = 0;
  int         in_idle_pct  = 0;
  int         out_idle_pct = 0;
  int         fail_count   = 0;
  int         cycle_cnt    = 0;
  src_pixel_t drv_pix;
  out_pixel_t want;

  nearest_upscale_int8_quantizer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel        (in_pixel),
    .in_frame_start  (in_frame_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_quant_value (out_quant_value),
    .out_col         (out_col),
    .out_row         (out_row),
    .out_run_last    (out_run_last),
    .out_frame_last  (out_frame_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  // Destination coordinate to the source coordinate it copies
  function automatic int src_of(input int d);
    return (d * SRC_SIDE) / DST_SIDE;
  endfunction

  // Q16 scale, round half up, add zero point, saturate to int8
  function automatic logic [QUANT_W-1:0] quant_of(input logic [PIX_W-1:0] p);
    longint v;
    v = longint'(p) * longint'(gain_cfg);
    v = (v + 32768) >>> 16;
    v = v + zero_cfg;
    if (v < -128) v = -128;
    if (v > 127) v = 127;
    return v[QUANT_W-1:0];
  endfunction

  // Keep one result back so the last one of a transaction can be flagged
  task automatic hold_result(input logic [PIX_W-1:0] p, input int col, input int row);
    if (held_ok) quant_q.push_back(held);
    held.quant      = quant_of(p);
    held.col        = col[COORD_W-1:0];
    held.row        = row[COORD_W-1:0];
    held.run_last   = 1'b0;
    held.frame_last = (col == DST_SIDE - 1) && (row == DST_SIDE - 1);
    held_ok         = 1'b1;
  endtask

  // Output pixels caused by one accepted source pixel
  task automatic resize_quantize(input logic [PIX_W-1:0] p, input logic fs);
    logic hit;
    int   x;
    held_ok = 1'b0;
    if (fs) begin
      scol = 0;
      srow = 0;
      dcol = 0;
      drow = 0;
    end
    row_buf[scol] = p;
    hit = (drow < DST_SIDE) && (src_of(drow) == srow);
    // columns of the current output row that copy this pixel
    while (dcol < DST_SIDE && src_of(dcol) == scol) begin
      if (hit) hold_result(p, dcol, drow);
      dcol++;
    end
    if (scol + 1 >= SRC_SIDE) begin
      if (hit) drow++;
      // replay further output rows that copy this source row
      while (drow < DST_SIDE && src_of(drow) == srow) begin
        for (x = 0; x < DST_SIDE; x++) hold_result(row_buf[src_of(x)], x, drow);
        drow++;
      end
      scol = 0;
      dcol = 0;
      if (srow + 1 >= SRC_SIDE) begin
        srow = 0;
        drow = 0;
      end else begin
        srow++;
      end
    end else begin
      scol++;
    end
    if (held_ok) begin
      held.run_last = 1'b1;
      quant_q.push_back(held);
    end
  endtask

  // ------------------------------------------------------------------------
  // Input driver: pops pending pixels, inserts idle bursts
  // ------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
        in_gap   <= $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        drv_pix        = pixel_q.pop_front();
        in_valid       <= 1'b1;
        in_pixel       <= drv_pix.pixel;
        in_frame_start <= drv_pix.frame_start;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure in bursts
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap   <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
      out_gap   <= $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ------------------------------------------------------------------------
  // Monitor: predict on input transactions, check output transactions
  // ------------------------------------------------------------------------
  task automatic check_field(input string what, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) resize_quantize(in_pixel, in_frame_start);
    if (rst_n && out_valid && out_ready) begin
      if (quant_q.size() == 0) begin
        $display("%0t: unexpected output pixel, col %0d row %0d value %0d", $time,
                 out_col, out_row, $signed(out_quant_value));
        fail_count++;
      end else begin
        want = quant_q.pop_front();
        check_field("quant_value", $signed(want.quant), $signed(out_quant_value));
        check_field("out_col", want.col, out_col);
        check_field("out_row", want.row, out_row);
        check_field("run_last", want.run_last, out_run_last);
        check_field("frame_last", want.frame_last, out_frame_last);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_GAIN: gain_cfg = val[GAIN_W-1:0];
      CFG_ZERO: zero_cfg = val[ZERO_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_pixel(input logic [PIX_W-1:0] p, input logic fs);
    src_pixel_t s;
    s.pixel       = p;
    s.frame_start = fs;
    pixel_q.push_back(s);
  endtask

  // Mostly raw values, with the rails favored
  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 3))
      0:       return GAIN_W'($urandom_range(0, 2000));
      1:       return GAIN_W'($urandom_range(40000, 140000));
      2:       return GAIN_W'($urandom_range(0, 800000));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // Wait until every pending pixel went in and every result came out
  task automatic wait_drain();
    do @(posedge clk); while (pixel_q.size() != 0 || in_valid || quant_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // ------------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------------
  initial begin
    int ph;
    int n;
    int restart_pct;
    int k;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: reset gain/zero, rails, frame restart in the middle of a row
    in_idle_pct  = 10;
    out_idle_pct = 10;
    queue_pixel(8'd0, 1'b1);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd128, 1'b0);
    queue_pixel(8'd127, 1'b0);
    queue_pixel(8'd1, 1'b0);
    queue_pixel(8'h55, 1'b0);
    queue_pixel(8'hAA, 1'b0);
    queue_pixel(8'd200, 1'b1);
    queue_pixel(8'd254, 1'b0);
    wait_drain();

    // Largest gain and zero point: largest product, saturation high
    write_reg(CFG_GAIN, 24'hFFFFFF);
    write_reg(CFG_ZERO, 24'h00007F);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd1, 1'b0);
    wait_drain();

    // Zero gain, lowest zero point
    write_reg(CFG_GAIN, 24'h000000);
    write_reg(CFG_ZERO, 24'h000080);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd0, 1'b0);
    wait_drain();

    // Half gain: rounding of exact halves goes up
    write_reg(CFG_GAIN, 24'h008000);
    write_reg(CFG_ZERO, 24'h000000);
    queue_pixel(8'd1, 1'b0);
    queue_pixel(8'd3, 1'b0);
    queue_pixel(8'd255, 1'b0);
    wait_drain();

    // Unity gain with top zero point clamps just past the rail
    write_reg(CFG_GAIN, 24'h010000);
    write_reg(CFG_ZERO, 24'h00007F);
    queue_pixel(8'd1, 1'b0);
    queue_pixel(8'd0, 1'b0);
    wait_drain();

    // Random phases; the first three continue one frame over several rows
    for (ph = 0; ph < 5; ph++) begin
      write_reg(CFG_ZERO, CFG_DATA_W'($urandom_range(0, 255)));
      write_reg(CFG_GAIN, rand_gain());
      restart_pct = 0;
      case (ph)
        0: begin n = 110; in_idle_pct = 20; out_idle_pct = 20; end
        1: begin n = 110; in_idle_pct = 0;  out_idle_pct = 30; end
        2: begin n = 110; in_idle_pct = 30; out_idle_pct = 0;  end
        3: begin n = 60;  in_idle_pct = 15; out_idle_pct = 15; restart_pct = 3; end
        default: begin n = 40; in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      for (k = 0; k < n; k++)
        queue_pixel(rand_pixel(), (ph == 0 && k == 0) || ($urandom_range(0, 99) < restart_pct));
      wait_drain();
    end

    if (fail_count == 0 && quant_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/nuq_pkg.sv
hdl/nuq_front.sv
hdl/nuq_queue.sv
hdl/nuq_back.sv
hdl/nearest_upscale_int8_quantizer.sv
sim/tb_top.sv
